// ===== rtl/assert_macros.svh =====
// Assertion helpers for the cache RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, disabled while reset is asserted.
`define SCC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cache check failed");

// Same check with its own message text.
`define SCC_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

// ===== rtl/scc_pkg.sv =====
// Shared types, codes and helper functions of the set-associative cache.
// No dependencies.
package scc_pkg;

  localparam int ADDR_W = 8;
  localparam int LINES  = 256;
  localparam int MAXW   = 4;
  localparam int CNT_W  = 16;

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;
  localparam logic [1:0] CMD_PRELOAD = 2'd3;

  localparam logic [1:0] REPL_RANDOM = 2'd0;
  localparam logic [1:0] REPL_LRU    = 2'd1;
  localparam logic [1:0] REPL_LFU    = 2'd2;

  localparam logic [2:0] CFG_CACHE_LOG2 = 3'd0;
  localparam logic [2:0] CFG_BLOCK_LOG2 = 3'd1;
  localparam logic [2:0] CFG_WAYS_LOG2  = 3'd2;
  localparam logic [2:0] CFG_REPL       = 3'd3;
  localparam logic [2:0] CFG_WHIT       = 3'd4;
  localparam logic [2:0] CFG_WMISS      = 3'd5;

  localparam logic [7:0] LFSR_TAP  = 8'hB8;
  localparam logic [7:0] LFSR_SEED = 8'h01;

  typedef struct packed {
    logic [3:0] blog;
    logic [1:0] wlog;
    logic [3:0] slog;
  } geom_t;

  typedef struct packed {
    logic [1:0] repl;
    logic       whp;
    logic       wmp;
  } policy_t;

  typedef struct packed {
    logic [7:0]       tag;
    logic             dirty;
    logic [1:0]       rank;
    logic [CNT_W-1:0] count;
  } meta_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    meta_t      data;
    logic       set_valid;
  } meta_wr_t;

  typedef struct packed {
    meta_t data;
    logic  ok;
    logic  valid;
  } meta_rd_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } byte_wr_t;

  typedef logic [MAXW-1:0][1:0]       rank_vec_t;
  typedef logic [MAXW-1:0][CNT_W-1:0] cnt_vec_t;

  function automatic geom_t calc_geom(logic [3:0] c, logic [3:0] b, logic [1:0] w);
    logic [3:0] cc;
    logic [3:0] bb;
    logic [1:0] ww;
    geom_t      g;
    cc = (c < 4'd3) ? 4'd3 : ((c > 4'd8) ? 4'd8 : c);
    ww = (w > 2'd2) ? 2'd2 : w;
    bb = (b > 4'd8) ? 4'd8 : b;
    if (bb + {2'b00, ww} > cc) bb = cc - {2'b00, ww};
    g.blog = bb;
    g.wlog = ww;
    g.slog = cc - bb - {2'b00, ww};
    return g;
  endfunction

  // Move way w to most recent; ranks above its old rank slide down.
  function automatic rank_vec_t touch(rank_vec_t rk, logic [1:0] w, logic [2:0] ways);
    logic [1:0] r;
    r = rk[w];
    for (int i = 0; i < MAXW; i++) begin
      if (3'(i) < ways && rk[i] > r) rk[i] = rk[i] - 2'd1;
    end
    rk[w] = 2'(ways - 3'd1);
    return rk;
  endfunction

endpackage

// ===== rtl/set_associative_cache_controller.sv =====
// Set-associative byte cache top level: configuration registers and memories.
// Depends on scc_pkg, scc_byte_ram, scc_meta_store and scc_ctrl.
//
// One command word at a time. A preload only writes the backing memory. A read
// or write reads the registered tag memory for each way in turn, decides, copies
// a dirty victim back and fills the line byte by byte where needed, accesses the
// byte and writes the metadata of every way back. A flush visits every line and
// copies each dirty one back byte by byte. Results wait in an output register, so
// the next command is taken while one is still unread. A configuration write to
// index 0 to 5 (CFG_CACHE_LOG2 to CFG_WMISS) drops every line without write-back.
module set_associative_cache_controller import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // address[7:0], write_data[15:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // set[4:0], tag_value[12:5], hit[13], line_filled[14], way[16:15],
  // read_data[24:17], dirty_after[25], hit_count[41:26], miss_count[57:42]
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [3:0] cache_log2_r;
  logic [3:0] block_log2_r;
  logic [1:0] ways_log2_r;
  logic [1:0] repl_r;
  logic       whp_r;
  logic       wmp_r;
  logic       cfg_clear;
  logic       flush_clear;
  geom_t      geom;
  policy_t    pol;

  meta_rd_t   meta_rd;
  meta_wr_t   meta_wr;
  logic [7:0] meta_raddr;
  byte_wr_t   data_wr;
  byte_wr_t   back_wr;
  logic [7:0] data_raddr;
  logic [7:0] data_rdata;
  logic [7:0] back_raddr;
  logic [7:0] back_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && (cfg_index <= CFG_WMISS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_log2_r <= 4'd8;
      block_log2_r <= 4'd2;
      ways_log2_r  <= 2'd1;
      repl_r       <= REPL_LRU;
      whp_r        <= 1'b1;
      wmp_r        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CACHE_LOG2: cache_log2_r <= cfg_data;
        CFG_BLOCK_LOG2: block_log2_r <= cfg_data;
        CFG_WAYS_LOG2:  ways_log2_r  <= cfg_data[1:0];
        CFG_REPL:       repl_r       <= cfg_data[1:0];
        CFG_WHIT:       whp_r        <= cfg_data[0];
        CFG_WMISS:      wmp_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign geom     = calc_geom(cache_log2_r, block_log2_r, ways_log2_r);
  assign pol.repl = repl_r;
  assign pol.whp  = whp_r;
  assign pol.wmp  = wmp_r;

  scc_meta_store u_meta (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (cfg_clear || flush_clear),
    .wr    (meta_wr),
    .raddr (meta_raddr),
    .rd    (meta_rd)
  );

  scc_byte_ram u_line_ram (
    .clk   (clk),
    .wr    (data_wr),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  scc_byte_ram u_back_ram (
    .clk   (clk),
    .wr    (back_wr),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

  scc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .geom        (geom),
    .pol         (pol),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .meta_raddr  (meta_raddr),
    .meta_rd     (meta_rd),
    .meta_wr     (meta_wr),
    .flush_clear (flush_clear),
    .data_raddr  (data_raddr),
    .data_rdata  (data_rdata),
    .data_wr     (data_wr),
    .back_raddr  (back_raddr),
    .back_rdata  (back_rdata),
    .back_wr     (back_wr)
  );

endmodule

// ===== rtl/scc_byte_ram.sv =====
// 256 x 8 synchronous RAM, one write and one registered read port.
// Depends on scc_pkg.
module scc_byte_ram import scc_pkg::*; (
  input  logic       clk,
  input  byte_wr_t   wr,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [LINES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scc_meta_store.sv =====
// Per-line tag, dirty, rank and use count memory with valid and written flags.
// Depends on scc_pkg.
module scc_meta_store import scc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  meta_wr_t   wr,
  input  logic [7:0] raddr,
  output meta_rd_t   rd
);

  meta_t            mem [LINES];
  logic             vld_mem [LINES];
  meta_t            rdata_r;
  logic             vld_rdata_r;
  logic [LINES-1:0] ok_r;
  logic             rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr]     <= wr.data;
      vld_mem[wr.addr] <= wr.set_valid;
    end
    rdata_r     <= mem[raddr];
    vld_rdata_r <= vld_mem[raddr];
  end

  // ok marks an entry written since the last clear; unwritten ones read as reset
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ok_r    <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr.we) ok_r[wr.addr] <= 1'b1;
      rd_ok_r <= ok_r[raddr];
    end
  end

  assign rd.data  = rdata_r;
  assign rd.ok    = rd_ok_r;
  assign rd.valid = rd_ok_r & vld_rdata_r;

endmodule

// ===== rtl/scc_ctrl.sv =====
// Command sequencer: lookup, victim choice, block copies, flush and results.
// Depends on scc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module scc_ctrl import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  geom_t       geom,
  input  policy_t     pol,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [7:0]  meta_raddr,
  input  meta_rd_t    meta_rd,
  output meta_wr_t    meta_wr,
  output logic        flush_clear,
  output logic [7:0]  data_raddr,
  input  logic [7:0]  data_rdata,
  output byte_wr_t    data_wr,
  output logic [7:0]  back_raddr,
  input  logic [7:0]  back_rdata,
  output byte_wr_t    back_wr
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_LK_RD   = 4'd2;
  localparam logic [3:0] S_LK_CAP  = 4'd3;
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_CP_RD   = 4'd5;
  localparam logic [3:0] S_CP_WR   = 4'd6;
  localparam logic [3:0] S_ACCESS  = 4'd7;
  localparam logic [3:0] S_RDCAP   = 4'd8;
  localparam logic [3:0] S_MWB     = 4'd9;
  localparam logic [3:0] S_FL_RD   = 4'd10;
  localparam logic [3:0] S_FL_CAP  = 4'd11;
  localparam logic [3:0] S_FL_NEXT = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  localparam logic [1:0] MODE_WB    = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  logic [3:0]  state_r;
  logic [1:0]  mode_r;
  logic [1:0]  cmd_r;
  logic [7:0]  addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  k_r;
  logic [1:0]  wk_r;
  logic [7:0]  line_i_r;
  meta_t       way_meta_r [MAXW];
  logic [MAXW-1:0] way_vld_r;
  logic        hit_r;
  logic        filled_r;
  logic [1:0]  vway_r;
  logic [1:0]  lway_r;
  logic        dirty_out_r;
  logic [7:0]  rdata_r;
  logic [7:0]  wb_line_r;
  logic [7:0]  wb_set_r;
  logic [7:0]  wb_tag_r;
  logic [15:0] hits_r;
  logic [15:0] misses_r;
  logic [7:0]  lfsr_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  // geometry of the current configuration
  logic [2:0] ways;
  logic [1:0] way_mask;
  logic [7:0] blk_mask;
  logic [7:0] set_mask;
  logic [7:0] nline_mask;
  logic [7:0] off;
  logic [7:0] set_full;
  logic [7:0] tag;
  logic [7:0] first;
  logic [7:0] lline;
  logic [7:0] wb_base;
  logic [7:0] fill_base;
  logic       is_rw;
  logic       nwa;

  assign ways       = 3'd1 << geom.wlog;
  assign way_mask   = 2'(ways - 3'd1);
  assign blk_mask   = 8'((9'd1 << geom.blog) - 9'd1);
  assign set_mask   = 8'((9'd1 << geom.slog) - 9'd1);
  assign nline_mask = 8'((9'd1 << (geom.slog + {2'b00, geom.wlog})) - 9'd1);
  assign off        = addr_r & blk_mask;
  assign set_full   = (addr_r >> geom.blog) & set_mask;
  assign tag        = addr_r >> (geom.blog + geom.slog);
  assign first      = 8'(set_full << geom.wlog);
  assign lline      = first + {6'b0, lway_r};
  assign wb_base    = 8'((16'(wb_tag_r) << (geom.slog + geom.blog))
                         | (16'(wb_set_r) << geom.blog));
  assign fill_base  = addr_r & ~blk_mask;
  assign is_rw      = (cmd_r == CMD_READ) || (cmd_r == CMD_WRITE);
  assign nwa        = (cmd_r == CMD_WRITE) && !hit_r && !filled_r;

  function automatic logic [7:0] byte_idx(logic [7:0] line, logic [7:0] k, logic [3:0] b);
    return 8'((16'(line) << b) + 16'(k));
  endfunction

  // lookup result and replacement decision over the captured ways
  rank_vec_t  d_rank;
  cnt_vec_t   d_cnt;
  logic       d_hit;
  logic [1:0] d_hw;
  logic       d_alloc;
  logic       d_found;
  logic [1:0] d_v;
  logic [7:0] d_lfsr;
  logic       d_wb;

  always_comb begin
    for (int i = 0; i < MAXW; i++) begin
      d_rank[i] = way_meta_r[i].rank;
      d_cnt[i]  = way_meta_r[i].count;
    end
    d_hit   = 1'b0;
    d_hw    = 2'd0;
    d_found = 1'b0;
    d_v     = 2'd0;
    d_lfsr  = lfsr_r;
    for (int i = 0; i < MAXW; i++) begin
      if (3'(i) < ways && way_vld_r[i] && way_meta_r[i].tag == tag && !d_hit) begin
        d_hit = 1'b1;
        d_hw  = 2'(i);
      end
    end
    d_alloc = !d_hit && (cmd_r == CMD_READ || !pol.wmp);
    if (d_hit) begin
      if (pol.repl == REPL_LFU) begin
        if (d_cnt[d_hw] != 16'hFFFF) d_cnt[d_hw] = d_cnt[d_hw] + 16'd1;
      end else if (pol.repl != REPL_RANDOM) begin
        d_rank = touch(d_rank, d_hw, ways);
      end
    end else if (d_alloc) begin
      for (int i = 0; i < MAXW; i++) begin
        if (3'(i) < ways && !way_vld_r[i] && !d_found) begin
          d_found = 1'b1;
          d_v     = 2'(i);
        end
      end
      if (d_found) begin
        if (pol.repl == REPL_LFU) d_cnt[d_v] = '0;
        else if (pol.repl != REPL_RANDOM) d_rank = touch(d_rank, d_v, ways);
      end else if (pol.repl == REPL_RANDOM) begin
        d_lfsr = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAP : 8'h00);
        d_v    = d_lfsr[1:0] & way_mask;
      end else if (pol.repl == REPL_LFU) begin
        for (int i = 1; i < MAXW; i++) begin
          if (3'(i) < ways && d_cnt[i] < d_cnt[d_v]) d_v = 2'(i);
        end
        d_cnt[d_v] = '0;
      end else begin
        for (int i = 1; i < MAXW; i++) begin
          if (3'(i) < ways && d_rank[i] < d_rank[d_v]) d_v = 2'(i);
        end
        d_rank = touch(d_rank, d_v, ways);
      end
    end
    d_wb = d_alloc && way_vld_r[d_v] && way_meta_r[d_v].dirty && pol.whp;
  end

  // memory port drive
  always_comb begin
    meta_raddr  = (state_r == S_FL_RD) ? line_i_r : first + {6'b0, wk_r};
    meta_wr     = '0;
    data_raddr  = 8'd0;
    back_raddr  = fill_base + k_r;
    data_wr     = '0;
    back_wr     = '0;
    flush_clear = (state_r == S_FL_NEXT) && (line_i_r == nline_mask);
    case (state_r)
      S_START: begin
        if (cmd_r == CMD_PRELOAD) back_wr = '{we: 1'b1, addr: addr_r, data: wdata_r};
      end
      S_CP_RD: begin
        if (mode_r != MODE_FILL) data_raddr = byte_idx(wb_line_r, k_r, geom.blog);
      end
      S_CP_WR: begin
        if (mode_r == MODE_FILL)
          data_wr = '{we: 1'b1, addr: byte_idx(lline, k_r, geom.blog), data: back_rdata};
        else
          back_wr = '{we: 1'b1, addr: wb_base + k_r, data: data_rdata};
      end
      S_ACCESS: begin
        data_raddr = byte_idx(lline, off, geom.blog);
        if (cmd_r == CMD_WRITE) begin
          if (!nwa) data_wr = '{we: 1'b1, addr: byte_idx(lline, off, geom.blog),
                                data: wdata_r};
          if (nwa || !pol.whp) back_wr = '{we: 1'b1, addr: addr_r, data: wdata_r};
        end
      end
      S_MWB: begin
        meta_wr.we        = 1'b1;
        meta_wr.addr      = first + {6'b0, wk_r};
        meta_wr.data      = way_meta_r[wk_r];
        meta_wr.set_valid = way_vld_r[wk_r];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      lfsr_r      <= LFSR_SEED;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            addr_r  <= in_tdata[7:0];
            wdata_r <= in_tdata[15:8];
            state_r <= S_START;
          end
        end
        S_START: begin
          hit_r       <= 1'b0;
          filled_r    <= 1'b0;
          dirty_out_r <= 1'b0;
          rdata_r     <= (cmd_r == CMD_PRELOAD) ? wdata_r : 8'd0;
          wk_r        <= 2'd0;
          line_i_r    <= 8'd0;
          case (cmd_r)
            CMD_PRELOAD: state_r <= S_DONE;
            CMD_FLUSH:   state_r <= S_FL_RD;
            default:     state_r <= S_LK_RD;
          endcase
        end
        S_LK_RD: state_r <= S_LK_CAP;
        S_LK_CAP: begin
          if (meta_rd.ok) begin
            way_meta_r[wk_r] <= '{tag: meta_rd.data.tag,
                                  dirty: meta_rd.data.dirty & meta_rd.valid,
                                  rank: meta_rd.data.rank, count: meta_rd.data.count};
          end else begin
            way_meta_r[wk_r] <= '{tag: 8'd0, dirty: 1'b0, rank: wk_r, count: '0};
          end
          way_vld_r[wk_r] <= meta_rd.valid;
          if (wk_r == way_mask) state_r <= S_DECIDE;
          else begin
            wk_r    <= wk_r + 2'd1;
            state_r <= S_LK_RD;
          end
        end
        S_DECIDE: begin
          if (d_hit) begin
            if (hits_r != 16'hFFFF) hits_r <= hits_r + 16'd1;
          end else if (misses_r != 16'hFFFF) begin
            misses_r <= misses_r + 16'd1;
          end
          lfsr_r <= d_lfsr;
          for (int i = 0; i < MAXW; i++) begin
            way_meta_r[i].rank  <= d_rank[i];
            way_meta_r[i].count <= d_cnt[i];
          end
          hit_r     <= d_hit;
          filled_r  <= d_alloc;
          vway_r    <= d_v;
          lway_r    <= d_hit ? d_hw : d_v;
          wb_line_r <= first + {6'b0, d_v};
          wb_set_r  <= set_full;
          wb_tag_r  <= way_meta_r[d_v].tag;
          k_r       <= 8'd0;
          if (d_wb) begin
            mode_r  <= MODE_WB;
            state_r <= S_CP_RD;
          end else if (d_alloc) begin
            mode_r  <= MODE_FILL;
            state_r <= S_CP_RD;
          end else begin
            state_r <= S_ACCESS;
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (k_r == blk_mask) begin
            k_r <= 8'd0;
            case (mode_r)
              MODE_WB: begin
                mode_r  <= MODE_FILL;
                state_r <= S_CP_RD;
              end
              MODE_FILL: begin
                way_meta_r[vway_r].tag   <= tag;
                way_meta_r[vway_r].dirty <= 1'b0;
                way_meta_r[vway_r].count <= '0;
                way_vld_r[vway_r]        <= 1'b1;
                state_r                  <= S_ACCESS;
              end
              default: state_r <= S_FL_NEXT;
            endcase
          end else begin
            k_r     <= k_r + 8'd1;
            state_r <= S_CP_RD;
          end
        end
        S_ACCESS: begin
          wk_r <= 2'd0;
          if (cmd_r == CMD_READ) begin
            state_r <= S_RDCAP;
          end else begin
            rdata_r <= wdata_r;
            if (!nwa) begin
              if (pol.whp) way_meta_r[lway_r].dirty <= 1'b1;
              dirty_out_r <= pol.whp | way_meta_r[lway_r].dirty;
            end
            state_r <= S_MWB;
          end
        end
        S_RDCAP: begin
          rdata_r <= data_rdata;
          state_r <= S_MWB;
        end
        S_MWB: begin
          if (wk_r == way_mask) state_r <= S_DONE;
          else wk_r <= wk_r + 2'd1;
        end
        S_FL_RD: state_r <= S_FL_CAP;
        S_FL_CAP: begin
          if (meta_rd.valid && meta_rd.ok && meta_rd.data.dirty) begin
            wb_line_r <= line_i_r;
            wb_set_r  <= line_i_r >> geom.wlog;
            wb_tag_r  <= meta_rd.data.tag;
            k_r       <= 8'd0;
            mode_r    <= MODE_FLUSH;
            state_r   <= S_CP_RD;
          end else begin
            state_r <= S_FL_NEXT;
          end
        end
        S_FL_NEXT: begin
          if (line_i_r == nline_mask) state_r <= S_DONE;
          else begin
            line_i_r <= line_i_r + 8'd1;
            state_r  <= S_FL_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload of the result word, loaded when the sequencer finishes
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, misses_r, hits_r, dirty_out_r, rdata_r,
                     (filled_r ? vway_r : 2'd0), filled_r, hit_r,
                     (is_rw ? tag : 8'd0), (is_rw ? set_full[4:0] : 5'd0)};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SCC_ASSERT(a_leave_idle, (in_tvalid && in_tready) |=> (state_r != S_IDLE))
  `SCC_ASSERT_MSG(a_hits_mono, $past(rst_n) |-> (hits_r >= $past(hits_r)),
                  "hit count went down")
  `SCC_ASSERT_MSG(a_copy_bound, (state_r == S_CP_WR) |-> (k_r <= blk_mask),
                  "block copy ran past the line")

endmodule

// ===== sim/set_associative_cache_controller_tb.sv =====
// Self-checking testbench for the set-associative cache controller.
// Needs scc_pkg and the cache RTL; it predicts every result word itself.
module set_associative_cache_controller_tb import scc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [15:0] misses;
    logic [15:0] hits;
    logic        dirty;
    logic [7:0]  rdata;
    logic [1:0]  way;
    logic        filled;
    logic        hit;
    logic [7:0]  tag;
    logic [4:0]  set;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_READ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_CACHE_LOG2;
  logic [3:0]  cfg_data = '0;

  set_associative_cache_controller uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- cache model ----------------
  logic [7:0]  m_tag [256];
  bit          m_valid [256];
  bit          m_dirty [256];
  logic [7:0]  m_byte [256];
  logic [1:0]  m_rank [256];
  logic [15:0] m_uses [256];
  logic [7:0]  m_mem [256];
  logic [7:0]  m_lfsr;
  logic [15:0] m_hits, m_misses;
  logic [3:0]  r_cache, r_block;
  logic [1:0]  r_ways, r_repl;
  bit          r_whp, r_wmp;
  int          gb, gw, gs;

  cache_result_t expq[$];
  int  mismatches = 0;
  int  n_items = 0, n_results = 0, n_hits_seen = 0, n_fills_seen = 0, n_cfg = 0;
  bit  calm = 1'b0;
  longint cycles = 0;

  function automatic void update_geometry();
    int c, b, w;
    c = r_cache; b = r_block; w = r_ways;
    if (c < 3) c = 3;
    if (c > 8) c = 8;
    if (w > 2) w = 2;
    if (b > 8) b = 8;
    if (b + w > c) b = c - w;
    gb = b; gw = w; gs = c - b - w;
  endfunction

  function automatic void clear_cache();
    update_geometry();
    for (int i = 0; i < 256; i++) begin
      m_tag[i] = '0; m_valid[i] = 0; m_dirty[i] = 0; m_byte[i] = '0; m_uses[i] = '0;
      m_rank[i] = 2'(i & ((1 << gw) - 1));
    end
  endfunction

  function automatic void write_back(int line, int set);
    int base;
    base = (int'(m_tag[line & 255]) << (gs + gb)) | (set << gb);
    for (int k = 0; k < (1 << gb); k++)
      m_mem[(base + k) & 255] = m_byte[((line << gb) + k) & 255];
    m_dirty[line & 255] = 0;
  endfunction

  function automatic void make_recent(int set, int way);
    int first, r;
    first = set << gw;
    r = m_rank[(first + way) & 255];
    for (int k = 0; k < (1 << gw); k++)
      if (m_rank[(first + k) & 255] > r) m_rank[(first + k) & 255]--;
    m_rank[(first + way) & 255] = 2'((1 << gw) - 1);
  endfunction

  function automatic int pick_and_fill(int set, int tag, int addr);
    int ways, first, way, line, base;
    bit lsb;
    ways = 1 << gw; first = set << gw; way = ways;
    for (int k = 0; k < ways; k++)
      if (!m_valid[(first + k) & 255]) begin
        way = k;
        break;
      end
    if (way < ways) begin
      if (r_repl == REPL_LFU) m_uses[(first + way) & 255] = '0;
      else if (r_repl != REPL_RANDOM) make_recent(set, way);
    end else if (r_repl == REPL_RANDOM) begin
      lsb = m_lfsr[0];
      m_lfsr = m_lfsr >> 1;
      if (lsb) m_lfsr ^= LFSR_TAP;
      way = m_lfsr & (ways - 1);
    end else if (r_repl == REPL_LFU) begin
      way = 0;
      for (int k = 1; k < ways; k++)
        if (m_uses[(first + k) & 255] < m_uses[(first + way) & 255]) way = k;
      m_uses[(first + way) & 255] = '0;
    end else begin
      way = 0;
      for (int k = 1; k < ways; k++)
        if (m_rank[(first + k) & 255] < m_rank[(first + way) & 255]) way = k;
      make_recent(set, way);
    end
    line = (first + way) & 255;
    if (m_valid[line] && m_dirty[line] && r_whp) write_back(line, set);
    base = addr & ~((1 << gb) - 1);
    for (int k = 0; k < (1 << gb); k++)
      m_byte[((line << gb) + k) & 255] = m_mem[(base + k) & 255];
    m_valid[line] = 1; m_dirty[line] = 0; m_tag[line] = 8'(tag);
    return way;
  endfunction

  function automatic cache_result_t predict_access(logic [1:0] cmd, int addr, int data);
    cache_result_t r;
    int set, tag, way, line, off, first;
    bit hit;
    r = '0; set = 0; tag = 0; way = 0; line = 0; hit = 0;
    update_geometry();
    if (cmd == CMD_PRELOAD) begin
      m_mem[addr] = 8'(data);
      r.rdata = 8'(data);
    end else if (cmd == CMD_FLUSH) begin
      for (int s = 0; s < (1 << gs); s++)
        for (int k = 0; k < (1 << gw); k++)
          if (m_valid[((s << gw) + k) & 255] && m_dirty[((s << gw) + k) & 255])
            write_back(((s << gw) + k) & 255, s);
      clear_cache();
    end else begin
      off = addr & ((1 << gb) - 1);
      set = (addr >> gb) & ((1 << gs) - 1);
      tag = (addr >> (gb + gs)) & 255;
      first = set << gw;
      for (int k = 0; k < (1 << gw); k++)
        if (m_valid[(first + k) & 255] && m_tag[(first + k) & 255] == tag) begin
          hit = 1; way = k; line = (first + k) & 255;
          break;
        end
      if (hit) begin
        if (m_hits != 16'hFFFF) m_hits++;
        if (r_repl == REPL_LFU) begin
          if (m_uses[line] != 16'hFFFF) m_uses[line]++;
        end else if (r_repl != REPL_RANDOM) begin
          make_recent(set, way);
        end
        way = 0;
      end else if (m_misses != 16'hFFFF) begin
        m_misses++;
      end
      if (cmd == CMD_READ) begin
        if (!hit) begin
          way = pick_and_fill(set, tag, addr);
          r.filled = 1;
          line = (first + way) & 255;
        end
        r.rdata = m_byte[((line << gb) + off) & 255];
      end else begin
        r.rdata = 8'(data);
        if (!hit && r_wmp) begin
          m_mem[addr] = 8'(data);
        end else begin
          if (!hit) begin
            way = pick_and_fill(set, tag, addr);
            r.filled = 1;
            line = (first + way) & 255;
          end
          m_byte[((line << gb) + off) & 255] = 8'(data);
          if (r_whp) m_dirty[line] = 1;
          else m_mem[addr] = 8'(data);
          r.dirty = m_dirty[line];
        end
      end
    end
    r.set = 5'(set); r.tag = 8'(tag); r.hit = hit; r.way = 2'(way);
    r.hits = m_hits; r.misses = m_misses;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_cmd(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
    expq.insert(expq.size(), predict_access(cmd, addr, data));
    n_items++;
    @(negedge clk);
  endtask

  // Idle point: stop sending and wait until all results are back.
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (expq.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CACHE_LOG2: r_cache = val;
      CFG_BLOCK_LOG2: r_block = val;
      CFG_WAYS_LOG2:  r_ways  = val[1:0];
      CFG_REPL:       r_repl  = val[1:0];
      CFG_WHIT:       r_whp   = val[0];
      CFG_WMISS:      r_wmp   = val[0];
      default: ;
    endcase
    clear_cache();
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic set_config(int c, int b, int w, int p, int h, int m);
    drain();
    write_reg(CFG_CACHE_LOG2, 4'(c));
    write_reg(CFG_BLOCK_LOG2, 4'(b));
    write_reg(CFG_WAYS_LOG2, 4'(w));
    write_reg(CFG_REPL, 4'(p));
    write_reg(CFG_WHIT, 4'(h));
    write_reg(CFG_WMISS, 4'(m));
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 15);

  // ---------------- checker ----------------
  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = cache_result_t'(out_tdata[57:0]);
      n_results++;
      if (got.hit) n_hits_seen++;
      if (got.filled) n_fills_seen++;
      if (expq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = expq.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: set %0d/%0d tag %h/%h hit %b/%b fill %b/%b",
                     n_results, want.set, got.set, want.tag, got.tag, want.hit, got.hit,
                     want.filled, got.filled, "  way %0d/%0d data %h/%h dirty %b/%b",
                     want.way, got.way, want.rdata, got.rdata, want.dirty, got.dirty,
                     "  hits %0d/%0d misses %0d/%0d (expected/actual)",
                     want.hits, got.hits, want.misses, got.misses);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // Every backing byte gets a value, so no line fill reads unwritten memory.
  task automatic test_preload_memory();
    for (int a = 0; a < 256; a++) send_cmd(CMD_PRELOAD, 8'(a), 8'($urandom));
  endtask

  task automatic test_directed();
    send_cmd(CMD_READ, 8'h00, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'h00);
    send_cmd(CMD_READ, 8'hFF, 8'hFF);
    send_cmd(CMD_WRITE, 8'hFF, 8'hFF);
    send_cmd(CMD_WRITE, 8'h80, 8'h00);
    send_cmd(CMD_WRITE, 8'h00, 8'hFF);
    send_cmd(CMD_READ, 8'h40, 8'h00);
    send_cmd(CMD_READ, 8'hC0, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'h00);
    send_cmd(CMD_FLUSH, 8'hFF, 8'hFF);
    send_cmd(CMD_READ, 8'hFF, 8'h00);
    send_cmd(CMD_PRELOAD, 8'hFF, 8'h00);
    send_cmd(CMD_PRELOAD, 8'h00, 8'hFF);
    send_cmd(CMD_READ, 8'h00, 8'h00);
    // no-allocate write miss, write-through hit, unused policy code
    set_config(8, 2, 1, 3, 0, 1);
    send_cmd(CMD_WRITE, 8'h21, 8'h5A);
    send_cmd(CMD_READ, 8'h21, 8'h00);
    send_cmd(CMD_WRITE, 8'h22, 8'hA5);
    send_cmd(CMD_FLUSH, 8'h00, 8'h00);
    send_cmd(CMD_READ, 8'h22, 8'h00);
  endtask

  task automatic random_burst(int count);
    logic [7:0] pool [16];
    int roll;
    logic [7:0] a;
    foreach (pool[i]) pool[i] = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      a = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 15)] : 8'($urandom);
      if (roll < 45)      send_cmd(CMD_READ, a, 8'($urandom));
      else if (roll < 80) send_cmd(CMD_WRITE, a, 8'($urandom));
      else if (roll < 96) send_cmd(CMD_PRELOAD, a, 8'($urandom));
      else                send_cmd(CMD_FLUSH, a, 8'($urandom));
    end
  endtask

  task automatic test_geometries();
    int plan [10][7] = '{
      '{8, 2, 1, 1, 1, 0, 75}, '{3, 0, 0, 0, 0, 0, 60}, '{8, 0, 0, 1, 1, 1, 75},
      '{8, 8, 2, 2, 1, 0, 25}, '{15, 15, 3, 3, 0, 1, 30}, '{0, 1, 2, 0, 1, 0, 60},
      '{5, 1, 1, 2, 1, 0, 75}, '{6, 2, 2, 0, 1, 1, 75}, '{7, 3, 1, 1, 0, 0, 75},
      '{4, 0, 2, 2, 1, 0, 75}};
    foreach (plan[p]) begin
      set_config(plan[p][0], plan[p][1], plan[p][2], plan[p][3], plan[p][4], plan[p][5]);
      calm = (p == 2);
      random_burst(plan[p][6]);
      calm = 1'b0;
    end
  endtask

  initial begin
    r_cache = 4'd8; r_block = 4'd2; r_ways = 2'd1;
    r_repl = REPL_LRU; r_whp = 1'b1; r_wmp = 1'b0;
    foreach (m_mem[i]) m_mem[i] = '0;
    m_lfsr = LFSR_SEED; m_hits = '0; m_misses = '0;
    clear_cache();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_preload_memory();
    test_directed();
    test_geometries();
    in_tvalid <= 1'b0;
    wait (expq.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d commands, %0d results (%0d hits, %0d fills), %0d register writes",
             n_items, n_results, n_hits_seen, n_fills_seen, n_cfg);
    $display("over the reset setup and eleven programmed ones; %0d mismatches", mismatches);
    if (mismatches == 0 && expq.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
